/* hw/rtl/tfm_pkg.sv */
package tfm_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int PIXEL_BITS    = 8;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
   localparam int DIM_BITS      = 13;
   localparam int SUM_BITS      = 45;
   localparam int MEAN_BITS     = 29;
   localparam int FRAC_BITS     = 8;
   localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
   localparam int COUNT_BITS    = 2 * DIM_BITS - 1;
   localparam int STEP_BITS     = $clog2(DIVIDEND_BITS + 1);
   localparam int GRAD_BITS     = 12;
   localparam int MAG_BITS      = 10;
   localparam int SQ_BITS       = 2 * MAG_BITS;
   localparam int ENERGY_BITS   = SQ_BITS + 1;
   localparam int LUMA_BITS     = 22;
   localparam int LUMA_SHIFT    = 14;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;

   // rounded BT.601 luma weights, Q14
   localparam logic [LUMA_BITS-1:0] WEIGHT_BLUE  = 22'd1868;
   localparam logic [LUMA_BITS-1:0] WEIGHT_GREEN = 22'd9617;
   localparam logic [LUMA_BITS-1:0] WEIGHT_RED   = 22'd4899;
   localparam logic [LUMA_BITS-1:0] LUMA_ROUND   = 22'd8192;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLOR_MODE   = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_TERM,
      S_ADV,
      S_DIVGO,
      S_DIV,
      S_OUT
   } state_type;

   // one column of the window: row r-2, row r-1, current row
   typedef struct packed {
      logic [PIXEL_BITS-1:0] p2;
      logic [PIXEL_BITS-1:0] p1;
      logic [PIXEL_BITS-1:0] cur;
   } column_type;

   typedef struct packed {
      logic valid;
      logic edge_right;   // center is the last column of the row
      logic col1;         // center is column 0, left reflects to column 1
      logic top;          // center row is row 0, upper row reflects
      logic bottom;       // center row is the last row
   } term_cmd_type;

   typedef struct packed {
      logic         pix_load;
      logic         load;
      term_cmd_type term;
      logic         acc_clear;
      logic         div_start;
      logic         rsp_load;
   } dp_cmd_type;

endpackage

/* hw/rtl/tfm_divider.sv */
module tfm_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [tfm_pkg::DIVIDEND_BITS-1:0]    dividend,
   input  logic [tfm_pkg::COUNT_BITS-1:0]       divisor,
   output logic                                 done,
   output logic [tfm_pkg::MEAN_BITS-1:0]        quotient
);
   import tfm_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_BITS-1:0]     cnt_ff, cnt_in;
   logic [DIVIDEND_BITS-1:0] q_ff, q_in;
   logic [COUNT_BITS-1:0]    rem_ff, rem_in;
   logic [COUNT_BITS:0]      shifted;
   logic [COUNT_BITS:0]      diff;
   logic                     ge;

   // one restoring step per cycle, MSB first
   assign shifted = {rem_ff, q_ff[DIVIDEND_BITS-1]};
   assign ge      = shifted >= {1'b0, divisor};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_BITS'(DIVIDEND_BITS);
         q_in    = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         q_in   = {q_ff[DIVIDEND_BITS-2:0], ge};
         rem_in = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff[MEAN_BITS-1:0];

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divide started while busy");
   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == STEP_BITS'(1)) |=> done_ff)
      else $error("divide finished without done");
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");

endmodule

/* hw/rtl/tfm_datapath.sv */
module tfm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  tfm_pkg::dp_cmd_type                cmd,
   input  logic [tfm_pkg::COL_BITS-1:0]       col_addr,
   input  logic [tfm_pkg::DIM_BITS-1:0]       width_eff,
   input  logic [tfm_pkg::DIM_BITS-1:0]       height_eff,
   input  logic                               color_mode,
   input  logic [tfm_pkg::PIXEL_BITS-1:0]     blue_or_gray,
   input  logic [tfm_pkg::PIXEL_BITS-1:0]     green_sample,
   input  logic [tfm_pkg::PIXEL_BITS-1:0]     red_sample,
   input  logic [tfm_pkg::MEAN_BITS-1:0]      quotient,
   output logic [tfm_pkg::DIVIDEND_BITS-1:0]  dividend,
   output logic [tfm_pkg::COUNT_BITS-1:0]     divisor,
   output logic [tfm_pkg::SUM_BITS-1:0]       gradient_energy_sum,
   output logic [tfm_pkg::MEAN_BITS-1:0]      mean_energy_q8
);
   import tfm_pkg::*;

   logic [PIXEL_BITS-1:0] line_a_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] line_b_mem [MAX_WIDTH];

   logic [PIXEL_BITS-1:0] blue_ff, green_ff, red_ff;
   logic [PIXEL_BITS-1:0] rd_a_ff, rd_b_ff;
   column_type            col_l_ff, col_m_ff, col_r_ff;
   logic [LUMA_BITS-1:0]  luma;
   logic [PIXEL_BITS-1:0] gray;
   column_type            new_col;

   column_type            sel_l, sel_c, sel_r;
   logic [PIXEL_BITS-1:0] ul, ml, dl, uc, dc, ur, mr, dr;
   logic signed [GRAD_BITS-1:0] gx, gy;
   logic [GRAD_BITS-1:0]  gx_abs, gy_abs;
   logic [MAG_BITS-1:0]   ax, ay;
   logic [SQ_BITS-1:0]    sqx, sqy;
   logic [ENERGY_BITS-1:0] energy_ff, energy_in;
   logic                   energy_valid_ff;
   logic [SUM_BITS-1:0]    acc_ff, acc_in;
   logic [SUM_BITS-1:0]    sum_hold_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [SUM_BITS-1:0]    rsp_sum_ff;
   logic [MEAN_BITS-1:0]   rsp_mean_ff;

   // gray conversion
   assign luma = WEIGHT_BLUE * LUMA_BITS'(blue_ff) + WEIGHT_GREEN * LUMA_BITS'(green_ff)
               + WEIGHT_RED * LUMA_BITS'(red_ff) + LUMA_ROUND;
   assign gray = color_mode ? luma[LUMA_SHIFT +: PIXEL_BITS] : blue_ff;

   assign new_col.p2  = rd_b_ff;
   assign new_col.p1  = rd_a_ff;
   assign new_col.cur = gray;

   // line buffers cascade: A holds row r-1, B holds row r-2
   always_ff @(posedge clock) begin
      if (cmd.pix_load) begin
         blue_ff  <= blue_or_gray;
         green_ff <= green_sample;
         red_ff   <= red_sample;
         rd_a_ff  <= line_a_mem[col_addr];
         rd_b_ff  <= line_b_mem[col_addr];
      end
      if (cmd.load) begin
         line_a_mem[col_addr] <= gray;
         line_b_mem[col_addr] <= rd_a_ff;
         col_l_ff <= col_m_ff;
         col_m_ff <= col_r_ff;
         col_r_ff <= new_col;
      end
   end

   // pick window columns for the term
   always_comb begin
      if (cmd.term.edge_right) begin
         sel_l = col_m_ff;
         sel_c = col_r_ff;
         sel_r = col_m_ff;
      end else begin
         sel_l = cmd.term.col1 ? col_r_ff : col_l_ff;
         sel_c = col_m_ff;
         sel_r = col_r_ff;
      end
   end

   // pick rows, reflecting at top and bottom
   always_comb begin
      if (cmd.term.bottom) begin
         ul = sel_l.p1;  ml = sel_l.cur; dl = sel_l.p1;
         uc = sel_c.p1;  dc = sel_c.p1;
         ur = sel_r.p1;  mr = sel_r.cur; dr = sel_r.p1;
      end else if (cmd.term.top) begin
         ul = sel_l.cur; ml = sel_l.p1;  dl = sel_l.cur;
         uc = sel_c.cur; dc = sel_c.cur;
         ur = sel_r.cur; mr = sel_r.p1;  dr = sel_r.cur;
      end else begin
         ul = sel_l.p2;  ml = sel_l.p1;  dl = sel_l.cur;
         uc = sel_c.p2;  dc = sel_c.cur;
         ur = sel_r.p2;  mr = sel_r.p1;  dr = sel_r.cur;
      end
   end

   assign gx = GRAD_BITS'($signed(GRAD_BITS'(ur)) - $signed(GRAD_BITS'(ul))
             + 2 * ($signed(GRAD_BITS'(mr)) - $signed(GRAD_BITS'(ml)))
             + $signed(GRAD_BITS'(dr)) - $signed(GRAD_BITS'(dl)));
   assign gy = GRAD_BITS'($signed(GRAD_BITS'(dl)) - $signed(GRAD_BITS'(ul))
             + 2 * ($signed(GRAD_BITS'(dc)) - $signed(GRAD_BITS'(uc)))
             + $signed(GRAD_BITS'(dr)) - $signed(GRAD_BITS'(ur)));

   assign gx_abs = gx[GRAD_BITS-1] ? GRAD_BITS'(-gx) : GRAD_BITS'(gx);
   assign gy_abs = gy[GRAD_BITS-1] ? GRAD_BITS'(-gy) : GRAD_BITS'(gy);
   assign ax     = gx_abs[MAG_BITS-1:0];
   assign ay     = gy_abs[MAG_BITS-1:0];
   assign sqx    = {{MAG_BITS{1'b0}}, ax} * {{MAG_BITS{1'b0}}, ax};
   assign sqy    = {{MAG_BITS{1'b0}}, ay} * {{MAG_BITS{1'b0}}, ay};
   assign energy_in = ENERGY_BITS'(sqx) + ENERGY_BITS'(sqy);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear || cmd.div_start) begin
         acc_in = '0;
      end else if (energy_valid_ff) begin
         acc_in = acc_ff + SUM_BITS'(energy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_valid_ff <= 1'b0;
         acc_ff          <= '0;
      end else begin
         energy_valid_ff <= cmd.term.valid;
         acc_ff          <= acc_in;
      end
      energy_ff <= energy_in;
      count_ff  <= COUNT_BITS'(width_eff) * COUNT_BITS'(height_eff);
      if (cmd.div_start) begin
         sum_hold_ff <= acc_ff;
      end
      if (cmd.rsp_load) begin
         rsp_sum_ff  <= sum_hold_ff;
         rsp_mean_ff <= quotient;
      end
   end

   assign dividend            = {acc_ff, {FRAC_BITS{1'b0}}};
   assign divisor             = count_ff;
   assign gradient_energy_sum = rsp_sum_ff;
   assign mean_energy_q8      = rsp_mean_ff;

endmodule

/* hw/rtl/tfm_controller.sv */
module tfm_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tfm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tfm_pkg::DIM_BITS-1:0]        csr_data,
   input  logic                                div_done,
   output tfm_pkg::dp_cmd_type                 dp_cmd,
   output logic [tfm_pkg::COL_BITS-1:0]        col_addr,
   output logic [tfm_pkg::DIM_BITS-1:0]        width_eff,
   output logic [tfm_pkg::DIM_BITS-1:0]        height_eff,
   output logic                                color_mode
);
   import tfm_pkg::*;

   state_type             state_ff, state_in;
   logic [1:0]            term_ff, term_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [DIM_BITS-1:0]   width_ff, height_ff;
   logic                  color_mode_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  csr_write;
   logic                  last_col, last_row, out_free;
   logic                  term_valid;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && (csr_index == CSR_FRAME_WIDTH
                      || csr_index == CSR_FRAME_HEIGHT || csr_index == CSR_COLOR_MODE);

   always_comb begin
      priority if (width_ff < DIM_BITS'(2)) width_eff = DIM_BITS'(2);
      else if (width_ff > DIM_BITS'(MAX_WIDTH)) width_eff = DIM_BITS'(MAX_WIDTH);
      else width_eff = width_ff;
      priority if (height_ff < DIM_BITS'(2)) height_eff = DIM_BITS'(2);
      else if (height_ff > DIM_BITS'(MAX_HEIGHT)) height_eff = DIM_BITS'(MAX_HEIGHT);
      else height_eff = height_ff;
   end

   assign last_col = {1'b0, col_ff} == width_eff - 1'b1;
   assign last_row = {1'b0, row_ff} == height_eff - 1'b1;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // term 0: center c-1, term 1: right edge, terms 2/3: same for the bottom row
   always_comb begin
      unique case (term_ff)
         2'd0: term_valid = row_ff != '0 && col_ff != '0;
         2'd1: term_valid = row_ff != '0 && last_col;
         2'd2: term_valid = last_row && col_ff != '0;
         2'd3: term_valid = last_row && last_col;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_LOAD;
         S_LOAD:  state_in = S_TERM;
         S_TERM:  if (term_ff == 2'd3) state_in = S_ADV;
         S_ADV:   state_in = (last_col && last_row) ? S_DIVGO : S_IDLE;
         S_DIVGO: state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      dp_cmd                 = '0;
      req_ready              = state_ff == S_IDLE;
      dp_cmd.pix_load        = state_ff == S_IDLE && req_valid;
      dp_cmd.load            = state_ff == S_LOAD;
      dp_cmd.term.valid      = state_ff == S_TERM && term_valid;
      dp_cmd.term.edge_right = term_ff[0];
      dp_cmd.term.bottom     = term_ff[1];
      dp_cmd.term.col1       = col_ff == COL_BITS'(1);
      dp_cmd.term.top        = row_ff == ROW_BITS'(1);
      dp_cmd.acc_clear       = csr_write;
      dp_cmd.div_start       = state_ff == S_DIVGO;
      dp_cmd.rsp_load        = state_ff == S_OUT && out_free;
   end

   always_comb begin
      term_in      = (state_ff == S_TERM) ? term_ff + 1'b1 : 2'd0;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_ADV) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end
      if (dp_cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         term_ff       <= 2'd0;
         col_ff        <= '0;
         row_ff        <= '0;
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         color_mode_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  width_ff      <= csr_data;
               CSR_FRAME_HEIGHT: height_ff     <= csr_data;
               CSR_COLOR_MODE:   color_mode_ff <= csr_data[0];
               default:          ;
            endcase
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign col_addr   = col_ff;
   assign color_mode = color_mode_ff;

   a_term_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TERM && term_ff == 2'd3) |=> state_ff == S_ADV)
      else $error("term sweep did not end in advance");
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < width_eff) else $error("column beyond row width");
   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.rsp_load |=> rsp_valid_ff) else $error("result not posted");
   a_term_only_in_term: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.term.valid |=> (state_ff == S_TERM || state_ff == S_ADV))
      else $error("energy term outside sweep");

endmodule

/* hw/rtl/tenengrad_focus_measure_top.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_blue_or_gray, req_green_sample, req_red_sample
// rsp       out        rsp_valid / rsp_ready  rsp_gradient_energy_sum, rsp_mean_energy_q8
// csr       in         csr_valid / csr_ready  csr_index, csr_data
//
// Each pixel item steps through accept with line buffer read, load and window shift,
// four energy term slots through one shared Sobel/square unit, then counter advance.
// On the last pixel of a frame there follow divide start, 53 one-bit division steps,
// seeing done, and loading the result once the output is free.
// Synchronous active-high reset restores 640x480 gray mode and clears counters and sum.
// A waiting result does not stall input; only a second frame end waits for rsp_ready.
module tenengrad_focus_measure_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tfm_pkg::PIXEL_BITS-1:0]      req_blue_or_gray,
   input  logic [tfm_pkg::PIXEL_BITS-1:0]      req_green_sample,
   input  logic [tfm_pkg::PIXEL_BITS-1:0]      req_red_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tfm_pkg::SUM_BITS-1:0]        rsp_gradient_energy_sum,
   output logic [tfm_pkg::MEAN_BITS-1:0]       rsp_mean_energy_q8,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tfm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tfm_pkg::DIM_BITS-1:0]        csr_data
);
   import tfm_pkg::*;

   dp_cmd_type               dp_cmd;
   logic [COL_BITS-1:0]      col_addr;
   logic [DIM_BITS-1:0]      width_eff, height_eff;
   logic                     color_mode;
   logic                     div_done;
   logic [MEAN_BITS-1:0]     quotient;
   logic [DIVIDEND_BITS-1:0] dividend;
   logic [COUNT_BITS-1:0]    divisor;

   // sequencing, counters and config registers
   tfm_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .div_done   (div_done),
      .dp_cmd     (dp_cmd),
      .col_addr   (col_addr),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .color_mode (color_mode)
   );

   // line buffers, window, gradient energy and accumulator
   tfm_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (dp_cmd),
      .col_addr            (col_addr),
      .width_eff           (width_eff),
      .height_eff          (height_eff),
      .color_mode          (color_mode),
      .blue_or_gray        (req_blue_or_gray),
      .green_sample        (req_green_sample),
      .red_sample          (req_red_sample),
      .quotient            (quotient),
      .dividend            (dividend),
      .divisor             (divisor),
      .gradient_energy_sum (rsp_gradient_energy_sum),
      .mean_energy_q8      (rsp_mean_energy_q8)
   );

   // frame mean: sum * 256 / pixel count
   tfm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dp_cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

endmodule

/* sim/tb_tenengrad_focus_measure_top.sv */
module tb_tenengrad_focus_measure_top;
   import tfm_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int DRAIN_CYCLES = 90;        // one pixel plus a frame end, with margin
   localparam int CYCLE_LIMIT  = 1_000_000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [PIXEL_BITS-1:0]   req_blue_or_gray = '0;
   logic [PIXEL_BITS-1:0]   req_green_sample = '0;
   logic [PIXEL_BITS-1:0]   req_red_sample = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [SUM_BITS-1:0]     rsp_gradient_energy_sum;
   logic [MEAN_BITS-1:0]    rsp_mean_energy_q8;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [DIM_BITS-1:0]     csr_data = '0;

   tenengrad_focus_measure_top uut (.*);

   // Stimulus table: register writes and pixels; expected frame results are
   // typed in only where the frame is degenerate and obviously zero.
   typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_CHK} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_IDX_BITS-1:0] reg_idx;
      logic [DIM_BITS-1:0]     reg_val;
      logic [7:0]              b, g, r;
      logic [SUM_BITS-1:0]     sum;
      logic [MEAN_BITS-1:0]    mean;
   } dir_row_type;

   typedef struct {
      logic [SUM_BITS-1:0]  sum;
      logic [MEAN_BITS-1:0] mean;
   } frame_result_type;

   // A 2-wide, 2-high frame reflects onto itself in both directions, so
   // gx and gy vanish everywhere and the frame energy is zero.
   dir_row_type dir_rows[24] = '{
      '{ROW_CFG, CSR_FRAME_WIDTH,  13'd2, 0, 0, 0, 0, 0},
      '{ROW_CFG, CSR_FRAME_HEIGHT, 13'd2, 0, 0, 0, 0, 0},
      '{ROW_CFG, CSR_COLOR_MODE,   13'd0, 0, 0, 0, 0, 0},
      '{ROW_PIX,     2'd0, 13'd0, 8'd0,   8'd0,   8'd0,   0, 0},
      '{ROW_PIX,     2'd0, 13'd0, 8'd255, 8'd255, 8'd255, 0, 0},
      '{ROW_PIX,     2'd0, 13'd0, 8'd255, 8'd0,   8'd0,   0, 0},
      '{ROW_PIX_CHK, 2'd0, 13'd0, 8'd0,   8'd255, 8'd255, 0, 0},
      '{ROW_CFG, CSR_COLOR_MODE,   13'd1, 0, 0, 0, 0, 0},
      '{ROW_PIX,     2'd0, 13'd0, 8'd255, 8'd255, 8'd255, 0, 0},
      '{ROW_PIX,     2'd0, 13'd0, 8'd0,   8'd0,   8'd0,   0, 0},
      '{ROW_PIX,     2'd0, 13'd0, 8'd255, 8'd0,   8'd0,   0, 0},
      '{ROW_PIX_CHK, 2'd0, 13'd0, 8'd0,   8'd255, 8'd255, 0, 0},
      '{ROW_CFG, CSR_FRAME_WIDTH,  13'd3, 0, 0, 0, 0, 0},
      '{ROW_CFG, CSR_FRAME_HEIGHT, 13'd3, 0, 0, 0, 0, 0},
      '{ROW_CFG, CSR_COLOR_MODE,   13'd0, 0, 0, 0, 0, 0},
      // 3x3 checkerboard of the extremes, checked by the predictor
      '{ROW_PIX, 2'd0, 13'd0, 8'd255, 8'd0, 8'd0, 0, 0},
      '{ROW_PIX, 2'd0, 13'd0, 8'd0,   8'd0, 8'd0, 0, 0},
      '{ROW_PIX, 2'd0, 13'd0, 8'd255, 8'd0, 8'd0, 0, 0},
      '{ROW_PIX, 2'd0, 13'd0, 8'd0,   8'd0, 8'd0, 0, 0},
      '{ROW_PIX, 2'd0, 13'd0, 8'd255, 8'd0, 8'd0, 0, 0},
      '{ROW_PIX, 2'd0, 13'd0, 8'd0,   8'd0, 8'd0, 0, 0},
      '{ROW_PIX, 2'd0, 13'd0, 8'd255, 8'd0, 8'd0, 0, 0},
      '{ROW_PIX, 2'd0, 13'd0, 8'd0,   8'd0, 8'd0, 0, 0},
      '{ROW_PIX, 2'd0, 13'd0, 8'd255, 8'd0, 8'd0, 0, 0}
   };

   // ---------------------------------------------------------------
   // Focus-measure predictor: three rotating rows, counters, sum
   // ---------------------------------------------------------------
   logic [7:0]          row_mem[3][MAX_WIDTH];
   logic [DIM_BITS-1:0] shadow_width  = WIDTH_RESET;
   logic [DIM_BITS-1:0] shadow_height = HEIGHT_RESET;
   logic                shadow_color  = 1'b0;
   logic [SUM_BITS-1:0] energy_sum    = '0;
   int                  cur_col = 0, cur_row = 0, cur_slot = 0;

   frame_result_type frame_results_due[$];
   int  fail_count = 0;
   int  frames_seen = 0;
   int  random_items = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;

   function automatic int clamp_dim(logic [DIM_BITS-1:0] v, int hi);
      return (v < 2) ? 2 : ((v > hi) ? hi : int'(v));
   endfunction

   function automatic longint unsigned sobel_energy(int up, int mid, int dn, int x, int w);
      int cl, cr, gx, gy;
      cl = (x == 0) ? 1 : x - 1;
      cr = (x == w - 1) ? w - 2 : x + 1;
      gx = (int'(row_mem[up][cr]) - int'(row_mem[up][cl]))
         + 2 * (int'(row_mem[mid][cr]) - int'(row_mem[mid][cl]))
         + (int'(row_mem[dn][cr]) - int'(row_mem[dn][cl]));
      gy = (int'(row_mem[dn][cl]) - int'(row_mem[up][cl]))
         + 2 * (int'(row_mem[dn][x]) - int'(row_mem[up][x]))
         + (int'(row_mem[dn][cr]) - int'(row_mem[up][cr]));
      return longint'(gx * gx) + longint'(gy * gy);
   endfunction

   function automatic void restart_frame();
      energy_sum = '0;
      cur_col = 0;
      cur_row = 0;
      cur_slot = 0;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
      case (idx)
         CSR_FRAME_WIDTH:  shadow_width  = val;
         CSR_FRAME_HEIGHT: shadow_height = val;
         CSR_COLOR_MODE:   shadow_color  = val[0];
         default: return;
      endcase
      restart_frame();
   endfunction

   // Advance the predictor by one pixel; return 1 with the frame result on
   // the frame's last pixel.
   function automatic bit predict_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] rd,
                                        output frame_result_type res);
      int w, h, c, r, p1, p2, up;
      longint unsigned acc, luma;
      w  = clamp_dim(shadow_width, MAX_WIDTH);
      h  = clamp_dim(shadow_height, MAX_HEIGHT);
      c  = (cur_col >= w) ? w - 1 : cur_col;
      r  = (cur_row >= h) ? h - 1 : cur_row;
      p1 = (cur_slot + 2) % 3;
      p2 = (cur_slot + 1) % 3;
      acc = energy_sum;
      if (shadow_color) begin
         luma = (1868 * longint'(b) + 9617 * longint'(g) + 4899 * longint'(rd) + 8192) >> 14;
         row_mem[cur_slot][c] = luma[7:0];
      end else begin
         row_mem[cur_slot][c] = b;
      end
      if (r >= 1) begin
         up = (r == 1) ? cur_slot : p2;
         if (c >= 1) acc += sobel_energy(up, p1, cur_slot, c - 1, w);
         if (c == w - 1) acc += sobel_energy(up, p1, cur_slot, w - 1, w);
         // last row reflects: the row below is the row above
         if (r == h - 1) begin
            if (c >= 1) acc += sobel_energy(p1, cur_slot, p1, c - 1, w);
            if (c == w - 1) acc += sobel_energy(p1, cur_slot, p1, w - 1, w);
         end
      end
      energy_sum = acc[SUM_BITS-1:0];
      c++;
      if (c == w) begin
         c = 0;
         r++;
         cur_slot = (cur_slot + 1) % 3;
         if (r == h) begin
            acc = energy_sum;
            res.sum  = energy_sum;
            res.mean = MEAN_BITS'((acc << 8) / (longint'(w) * longint'(h)));
            restart_frame();
            return 1'b1;
         end
      end
      cur_col = c;
      cur_row = r;
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------
   // Clock, timeout, receiver, result checker
   // ---------------------------------------------------------------
   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: drop ready at random by the current idle rate.
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each accepted result against the oldest frame expected.
   always @(posedge clock) begin
      frame_result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         frames_seen++;
         if (frame_results_due.size() == 0) begin
            $error("unexpected result: sum %0d mean %0d",
                   rsp_gradient_energy_sum, rsp_mean_energy_q8);
            fail_count++;
         end else begin
            due = frame_results_due.pop_front();
            if (rsp_gradient_energy_sum !== due.sum) begin
               $error("gradient_energy_sum: expected %0d, got %0d",
                      due.sum, rsp_gradient_energy_sum);
               fail_count++;
            end
            if (rsp_mean_energy_q8 !== due.mean) begin
               $error("mean_energy_q8: expected %0d, got %0d", due.mean, rsp_mean_energy_q8);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Drivers; every task starts and ends right after a rising edge
   // ---------------------------------------------------------------

   // Hold the pixel until accepted, then predict; idle afterwards at random.
   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] rd,
                             bit typed = 0, frame_result_type typed_res = '{0, 0});
      frame_result_type res;
      req_valid        <= 1'b1;
      req_blue_or_gray <= b;
      req_green_sample <= g;
      req_red_sample   <= rd;
      do @(posedge clock); while (!req_ready);
      if (predict_pixel(b, g, rd, res))
         frame_results_due.push_back(typed ? typed_res : res);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Pause input until every expected frame result has come, then let the
   // block settle so that no work is in flight.
   task automatic drain();
      req_valid <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_register(idx, val);
   endtask

   task automatic set_geometry(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h, logic mode);
      drain();
      write_register(CSR_FRAME_WIDTH, w);
      write_register(CSR_FRAME_HEIGHT, h);
      write_register(CSR_COLOR_MODE, {{(DIM_BITS-1){1'b0}}, mode});
   endtask

   // Random pixel, biased toward the extremes now and then.
   function automatic logic [7:0] rand_sample();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   // Stream count pixels of random content under the current geometry.
   task automatic stream_pixels(int count, bit count_random);
      repeat (count) begin
         send_pixel(rand_sample(), rand_sample(), rand_sample());
         if (count_random) random_items++;
      end
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int w, h, n;
      frame_result_type typed_res;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: walk it, draining before each register write.
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            drain();
            write_register(dir_rows[i].reg_idx, dir_rows[i].reg_val);
         end else begin
            typed_res = '{dir_rows[i].sum, dir_rows[i].mean};
            send_pixel(dir_rows[i].b, dir_rows[i].g, dir_rows[i].r,
                       dir_rows[i].kind == ROW_PIX_CHK, typed_res);
         end
      end

      // Out-of-range geometry saturates: 0 and 1 clamp to 2, 8191 to the maximum.
      // Under the huge geometries a short run must end no frame.
      set_geometry(13'd0, 13'd1, 1'b1);
      stream_pixels(8, 0);
      set_geometry(13'd8191, 13'd1, 1'b0);
      stream_pixels(60, 0);
      set_geometry(13'd1, 13'd8191, 1'b1);
      stream_pixels(60, 0);

      // Random frames under three idling regimes: sender light / receiver heavy,
      // then swapped, then no idling at all.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 54 : 0;
         recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 15 : 0;
         while (random_items < 300 * (phase + 1)) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 9);
            h = $urandom_range(2, 7);
            set_geometry(DIM_BITS'(w), DIM_BITS'(h), 1'($urandom));
            // Several frames back to back, sometimes cut short by the next write.
            n = w * h * $urandom_range(1, 3);
            if ($urandom_range(7) == 0) n = $urandom_range(1, n - 1);
            stream_pixels(n / 2, 1);
            // Hold off mid-stream now and then until the block has caught up.
            if ($urandom_range(5) == 0) drain();
            stream_pixels(n - n / 2, 1);
         end
      end

      drain();
      $display("Covered: saturated and extreme geometry, gray and BGR modes, %0d random pixels,",
               random_items);
      $display("         %0d frame results checked, with idling on both channels.", frames_seen);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
